// ----- design/assert_macros.svh -----
// Assertion shorthands used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, written as antecedent and consequent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/bfpa_pkg.sv -----
package bfpa_pkg;

  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_SIZE_BITS  = 16;

  localparam int NUM_BLOCKS_W = 7;
  localparam int SLOT_W       = 6;
  localparam int REQ_W        = 16;
  localparam int TOTAL_W      = 22;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3F_FFFF;

  // config port: byte address, one 32-bit word per register
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_NUM_BLOCKS = 1'b0;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [1:0] STAT_LOADED = 2'd0;
  localparam logic [1:0] STAT_ALLOC  = 2'd1;
  localparam logic [1:0] STAT_NOFIT  = 2'd2;
  localparam logic [1:0] STAT_RANGE  = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] slot;
    logic [REQ_W-1:0]  request_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  chosen_block;
    logic [REQ_W-1:0]   leftover;
    logic [TOTAL_W-1:0] internal_frag_total;
    logic [TOTAL_W-1:0] free_total;
  } out_item_t;

endpackage

// ----- design/bfpa_ram.sv -----
module bfpa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/best_fit_partition_allocator.sv -----
// Best-fit fixed-partition allocator. A load beat writes a partition size
// into a slot and marks it free; a request beat scans the partition RAM one
// entry per clock and grants the smallest free partition that holds the
// request (lowest index on ties). Every item gives exactly one result beat,
// shown for one cycle on out_valid; the receiver cannot stall it. An item
// keeps busy high through the scan of the single-port partition RAM over
// min(num_blocks, MAX_BLOCKS) entries, a drain of its read register, then
// three passes through the one shared add/subtract unit (free total,
// leftover, fragmentation total). With that count at zero there is no scan
// and no drain. The result strobe comes in the cycle busy drops, and a new
// start is taken in that same cycle. The taken bit lives in the RAM word
// next to the size and every in-range load clears it, so no clearing pass
// follows reset.
`include "assert_macros.svh"

module best_fit_partition_allocator import bfpa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  // result channel
  output logic              out_valid,
  output out_item_t         out_item,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int CW    = ($clog2(MAX_BLOCKS + 1) > NUM_BLOCKS_W) ?
                         $clog2(MAX_BLOCKS + 1) : NUM_BLOCKS_W;
  localparam int ACC_W = SIZE_BITS + IW + 1;          // exact free-bytes sum
  localparam int AW    = (ACC_W > TOTAL_W + 1) ? ACC_W : TOTAL_W + 1;
  localparam int MW    = SIZE_BITS + 1;               // {taken, size}

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ADJ,
    S_LEFT,
    S_FRAG
  } state_t;

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [AW-1:0] v);
    return (v > AW'(TOTAL_MAX)) ? TOTAL_MAX : v[TOTAL_W-1:0];
  endfunction

  // control
  state_t                  state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    found_r, found_nxt;
  logic [NUM_BLOCKS_W-1:0] num_blocks_r, num_blocks_nxt;
  logic [TOTAL_W-1:0]      int_sum_r, int_sum_nxt;
  // item context and datapath
  logic                    op_r, op_nxt;
  logic                    ld_ok_r, ld_ok_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [SIZE_BITS-1:0]    req_r, req_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [IW-1:0]           addr_r, addr_nxt;
  logic [IW-1:0]           rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]           best_r, best_nxt;
  logic [SIZE_BITS-1:0]    best_size_r, best_size_nxt;
  logic [SIZE_BITS-1:0]    left_r, left_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  out_item_t               out_item_r, out_item_nxt;

  // shared add/subtract unit
  logic [AW-1:0]           ua, ub, ures;
  logic                    usub;

  // partition RAM
  logic                    ram_we;
  logic [IW-1:0]           ram_addr;
  logic [MW-1:0]           ram_wdata, ram_rdata;

  // misc
  logic                    cfg_we;
  logic [CW-1:0]           num_ext, cnt_now;
  logic [SIZE_BITS+REQ_W-1:0] req_wide;
  logic [SIZE_BITS-1:0]    req_in;
  logic [IW+SLOT_W-1:0]    slot_wide;
  logic [IW-1:0]           slot_idx;
  logic [IW+SLOT_W-1:0]    best_wide;
  logic [SIZE_BITS+REQ_W-1:0] left_wide;
  logic                    row_taken;
  logic [SIZE_BITS-1:0]    row_size;
  logic                    row_incl, row_better;
  logic [TOTAL_W-1:0]      frag_val;

  bfpa_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign ures = usub ? (ua - ub) : (ua + ub);

  // effective partition count: num_blocks clipped to the table depth
  assign num_ext = CW'(num_blocks_r);
  assign cnt_now = (num_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : num_ext;

  // request size masked or zero-extended to the stored size width
  assign req_wide = {{SIZE_BITS{1'b0}}, in_item.request_size};
  assign req_in   = req_wide[SIZE_BITS-1:0];

  assign slot_wide = {{IW{1'b0}}, slot_r};
  assign slot_idx  = slot_wide[IW-1:0];
  assign best_wide = {{SLOT_W{1'b0}}, best_r};
  assign left_wide = {{REQ_W{1'b0}}, left_r};

  // scan row evaluation
  assign row_taken  = ram_rdata[SIZE_BITS];
  assign row_size   = ram_rdata[SIZE_BITS-1:0];
  // a load excludes its own slot: the new size is added after the scan
  assign row_incl   = !row_taken &&
                      !(op_r == OP_LOAD && ld_ok_r && rd_idx_r == slot_idx);
  // strict compare keeps the lowest index on equal sizes
  assign row_better = (op_r == OP_REQUEST) && !row_taken && (row_size >= req_r) &&
                      (!found_r || (row_size < best_size_r));

  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1] == REG_NUM_BLOCKS) ?
                  CFG_DW'(num_blocks_r) : '0;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = addr_r;
    found_nxt      = found_r;
    num_blocks_nxt = num_blocks_r;
    int_sum_nxt    = int_sum_r;
    op_nxt         = op_r;
    ld_ok_nxt      = ld_ok_r;
    slot_nxt       = slot_r;
    req_nxt        = req_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    best_nxt       = best_r;
    best_size_nxt  = best_size_r;
    left_nxt       = left_r;
    acc_nxt        = acc_r;
    out_item_nxt   = out_item_r;
    ua             = AW'(acc_r);
    ub             = '0;
    usub           = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = addr_r;
    ram_wdata      = {1'b0, req_r};
    frag_val       = int_sum_r;

    if (cfg_we && paddr[CFG_AW-1] == REG_NUM_BLOCKS) begin
      num_blocks_nxt = pwdata[NUM_BLOCKS_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = in_item.operation;
          slot_nxt      = in_item.slot;
          req_nxt       = req_in;
          cnt_nxt       = cnt_now;
          ld_ok_nxt     = CW'(in_item.slot) < cnt_now;
          acc_nxt       = '0;
          found_nxt     = 1'b0;
          best_nxt      = '0;
          best_size_nxt = '0;
          addr_nxt      = '0;
          state_nxt     = (cnt_now == '0) ? S_ADJ : S_SCAN;
        end
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = addr_r;
        addr_nxt   = addr_r + IW'(1);
        if (CW'(addr_r) == cnt_r - CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_ADJ;
      end
      S_ADJ: begin
        // free total after the item, and write back the touched entry
        if (op_r == OP_LOAD && ld_ok_r) begin
          ram_we    = 1'b1;
          ram_addr  = slot_idx;
          ram_wdata = {1'b0, req_r};
          ub        = AW'(req_r);
          acc_nxt   = ures[ACC_W-1:0];
        end else if (found_r) begin
          ram_we    = 1'b1;
          ram_addr  = best_r;
          ram_wdata = {1'b1, best_size_r};
          ub        = AW'(best_size_r);
          usub      = 1'b1;
          acc_nxt   = ures[ACC_W-1:0];
        end
        state_nxt = S_LEFT;
      end
      S_LEFT: begin
        ua        = AW'(best_size_r);
        ub        = AW'(req_r);
        usub      = 1'b1;
        left_nxt  = found_r ? ures[SIZE_BITS-1:0] : '0;
        state_nxt = S_FRAG;
      end
      S_FRAG: begin
        ua = AW'(int_sum_r);
        ub = AW'(left_r);
        if (found_r) begin
          frag_val = sat_total(ures);
        end
        int_sum_nxt = frag_val;
        if (op_r == OP_LOAD) begin
          out_item_nxt.status = ld_ok_r ? STAT_LOADED : STAT_RANGE;
        end else begin
          out_item_nxt.status = found_r ? STAT_ALLOC : STAT_NOFIT;
        end
        out_item_nxt.chosen_block        = found_r ? best_wide[SLOT_W-1:0] : '0;
        out_item_nxt.leftover            = left_wide[REQ_W-1:0];
        out_item_nxt.internal_frag_total = frag_val;
        out_item_nxt.free_total          = sat_total(AW'(acc_r));
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // one RAM row per cycle lands here during SCAN and DRAIN
    if (rd_vld_r) begin
      ub      = row_incl ? AW'(row_size) : '0;
      acc_nxt = ures[ACC_W-1:0];
      if (row_better) begin
        found_nxt     = 1'b1;
        best_nxt      = rd_idx_r;
        best_size_nxt = row_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ld_ok_r     <= ld_ok_nxt;
    slot_r      <= slot_nxt;
    req_r       <= req_nxt;
    cnt_r       <= cnt_nxt;
    addr_r      <= addr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_r      <= best_nxt;
    best_size_r <= best_size_nxt;
    left_r      <= left_nxt;
    acc_r       <= acc_nxt;
    out_item_r  <= out_item_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      num_blocks_r <= '0;
      int_sum_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_vld_r     <= rd_vld_nxt;
      found_r      <= found_nxt;
      num_blocks_r <= num_blocks_nxt;
      int_sum_r    <= int_sum_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // one strobe per item, never back to back
  `ASSERT_CLK(a_strobe_single, clk, rst_n, out_valid_r |=> !out_valid_r, "double result strobe")
  // an accepted command makes the block busy
  `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept without busy")
  // the result is shown only once the sequencer is back in idle
  `ASSERT_IMPLIES(a_strobe_idle, clk, rst_n, out_valid_r, state_r == S_IDLE, "strobe while busy")
  // the scan never addresses past the effective count
  `ASSERT_IMPLIES(a_scan_bound, clk, rst_n, state_r == S_SCAN, CW'(addr_r) < cnt_r, "scan overrun")

endmodule

// ----- verif/tb_best_fit_partition_allocator.sv -----
`timescale 1ns / 100ps

// Testbench for the best-fit partition allocator.
// Each accepted command beat is run through a local model of the partition
// table. The model's result is queued and compared field by field with the
// result beat, which the block shows for one cycle on out_valid.
module tb_best_fit_partition_allocator import bfpa_pkg::*;;

  localparam logic [CFG_AW-1:0] NUM_BLOCKS_ADDR = CFG_AW'(4 * REG_NUM_BLOCKS);
  localparam int MAX_GAP = 90;  // longest sender pause, in cycles

  logic              clk;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  best_fit_partition_allocator u_top (
    .clk, .rst_n,
    .start, .busy, .in_item,
    .out_valid, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Local copy of the partition table and totals, updated at each accepted
  // command beat. The block's RAM contents are undefined until loaded, so
  // the stimulus never lets a search or the free-sum scan see a slot below
  // the count that has not been loaded yet.
  // ---------------------------------------------------------------------
  logic [REQ_W-1:0]        part_size [DEF_MAX_BLOCKS];
  bit                      part_taken [DEF_MAX_BLOCKS];
  logic [TOTAL_W-1:0]      frag_total = '0;
  logic [TOTAL_W-1:0]      free_total = '0;
  logic [NUM_BLOCKS_W-1:0] blocks_cfg = '0;

  out_item_t pending_results [$];  // predicted result beats, oldest first
  int mismatches = 0;
  int n_loads = 0, n_grants = 0, n_nofits = 0, n_rejects = 0, n_cfg_writes = 0;

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Counts above the table size act as the table size.
  function automatic int unsigned active_blocks();
    return (blocks_cfg > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : blocks_cfg;
  endfunction

  function automatic out_item_t allocate_step(input in_item_t it);
    out_item_t       res;
    int unsigned     active;
    int unsigned     best;
    bit              found;
    longint unsigned acc;
    res    = '0;
    active = active_blocks();
    if (it.operation == OP_LOAD) begin
      // a load (even onto a taken slot) stores the size and frees the slot
      if (it.slot < active) begin
        part_size[it.slot]  = it.request_size;
        part_taken[it.slot] = 1'b0;
        res.status = STAT_LOADED;
        n_loads++;
      end else begin
        res.status = STAT_RANGE;
        n_rejects++;
      end
    end else begin
      // smallest free partition that holds the request; strict < keeps the
      // lowest index on ties
      found = 1'b0;
      best  = 0;
      for (int k = 0; k < active; k++) begin
        if (!part_taken[k] && part_size[k] >= it.request_size &&
            (!found || part_size[k] < part_size[best])) begin
          best  = k;
          found = 1'b1;
        end
      end
      if (found) begin
        part_taken[best]   = 1'b1;
        res.status         = STAT_ALLOC;
        res.chosen_block   = SLOT_W'(best);
        res.leftover       = part_size[best] - it.request_size;
        acc                = frag_total + res.leftover;
        frag_total         = (acc > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(acc);
        n_grants++;
      end else begin
        res.status = STAT_NOFIT;
        n_nofits++;
      end
    end
    // free total is a fresh scan under the current count
    acc = 0;
    for (int k = 0; k < active; k++)
      if (!part_taken[k]) acc += part_size[k];
    free_total = (acc > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(acc);
    res.internal_frag_total = frag_total;
    res.free_total          = free_total;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker. The receiver cannot stall, so every cycle with
  // out_valid high is a result beat taken at the closing edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result beat, status", 0, out_item.status);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          flag_mismatch("status", want.status, out_item.status);
        if (out_item.chosen_block !== want.chosen_block)
          flag_mismatch("chosen_block", want.chosen_block, out_item.chosen_block);
        if (out_item.leftover !== want.leftover)
          flag_mismatch("leftover", want.leftover, out_item.leftover);
        if (out_item.internal_frag_total !== want.internal_frag_total)
          flag_mismatch("internal_frag_total", want.internal_frag_total,
                        out_item.internal_frag_total);
        if (out_item.free_total !== want.free_total)
          flag_mismatch("free_total", want.free_total, out_item.free_total);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Command side. start stays high from one beat straight into the next
  // when there is no pause; every idle path lowers it first, so start gets
  // a single nonblocking write per time step.
  // ---------------------------------------------------------------------

  // Drop start and hold until every result is back and the block is idle.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
  endtask

  // Present one beat, with a random pause first; returns at the accepting edge.
  task automatic send_item(input in_item_t it, input int idle_pct);
    int gap;
    gap = 0;
    // pauses run up to past the longest scan, so they end in every phase
    // of the block's work
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(allocate_step(it));
  endtask

  task automatic issue(input logic op, input int slot, input int size);
    in_item_t it;
    it.operation    = op;
    it.slot         = SLOT_W'(slot);
    it.request_size = REQ_W'(size);
    send_item(it, 0);
  endtask

  // APB write of the block count, then a read back of it. Only while idle.
  task automatic cfg_write(input logic [NUM_BLOCKS_W-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_BLOCKS_ADDR;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    blocks_cfg = value;
    n_cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(value)) flag_mismatch("num_blocks read back", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [REQ_W-1:0] rand_size();
    case ($urandom_range(4))
      0:       return REQ_W'($urandom_range(0, 255));
      1:       return ($urandom_range(1) != 0) ? '1 : '0;
      default: return REQ_W'($urandom);
    endcase
  endfunction

  // count settings: empty, tiny, full, oversized, and anything between
  function automatic logic [NUM_BLOCKS_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'(DEF_MAX_BLOCKS);
      4:       return '1;
      5:       return 7'($urandom_range(DEF_MAX_BLOCKS + 1, 127));
      default: return 7'($urandom_range(1, DEF_MAX_BLOCKS));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Count still at its reset value of zero: nothing fits, nothing loads.
  task automatic test_empty_table();
    issue(OP_REQUEST, 0, 0);
    issue(OP_REQUEST, 63, 16'hFFFF);
    issue(OP_LOAD, 0, 16'h1234);
    issue(OP_LOAD, 63, 16'hFFFF);
  endtask

  // Grow the count one slot at a time and load the new top slot, so no
  // scan ever touches an unloaded entry. Ends with all 64 slots at the
  // largest size, which also gives the largest free total.
  task automatic test_fill_table();
    for (int k = 1; k <= DEF_MAX_BLOCKS; k++) begin
      cfg_write(7'(k));
      issue(OP_LOAD, k - 1, 16'hFFFF);
    end
  endtask

  task automatic test_directed_cases();
    // full table, every slot free at 0xFFFF
    issue(OP_REQUEST, 5, 16'hFFFF);   // exact fit, all equal -> slot 0
    issue(OP_REQUEST, 63, 0);         // zero request, full leftover -> slot 1
    issue(OP_LOAD, 63, 0);            // zero-size partition in the top slot
    issue(OP_REQUEST, 0, 0);          // zero fits the zero partition best
    issue(OP_LOAD, 0, 100);           // reload of a taken slot frees it
    issue(OP_REQUEST, 0, 50);         // best fit is the reloaded slot
    issue(OP_LOAD, 10, 300);
    issue(OP_LOAD, 20, 300);
    issue(OP_REQUEST, 0, 200);        // tie on size -> lower index
    issue(OP_REQUEST, 0, 300);
    // oversized count acts as the full table
    cfg_write('1);
    issue(OP_LOAD, 63, 16'hFFFF);
    issue(OP_REQUEST, 0, 1);
    // small count: loads at or past it are rejected, search stays below it
    cfg_write(7'd3);
    issue(OP_LOAD, 3, 5);
    issue(OP_LOAD, 63, 5);
    issue(OP_REQUEST, 0, 16'hFFFF);   // slots 0..2 all taken -> no fit
    issue(OP_LOAD, 1, 16'hFFFF);
    issue(OP_REQUEST, 0, 0);
    issue(OP_REQUEST, 0, 0);          // no fit again
    cfg_write(7'd1);
    issue(OP_LOAD, 0, 0);
    issue(OP_REQUEST, 0, 0);
    cfg_write('0);
    issue(OP_REQUEST, 0, 0);
    issue(OP_LOAD, 0, 7);
  endtask

  // Mostly well-formed traffic: in-range loads and requests aimed at a
  // stored size so that most of them are granted; the rest is random.
  task automatic test_random(input int idle_pct, input int n_items);
    in_item_t    it;
    int unsigned active;
    int unsigned k;
    int unsigned trim;
    for (int i = 0; i < n_items; i++) begin
      if (i % 30 == 0) cfg_write(pick_count());
      // now and then hold off until the block has fully drained
      if ($urandom_range(39) == 0) wait_drained();
      active = active_blocks();
      if ($urandom_range(99) < 45) begin
        it.operation = OP_LOAD;
        if (active > 0 && $urandom_range(9) != 0)
          it.slot = SLOT_W'($urandom_range(active - 1));
        else
          it.slot = SLOT_W'($urandom_range(63));
        it.request_size = rand_size();
      end else begin
        it.operation = OP_REQUEST;
        it.slot      = SLOT_W'($urandom_range(63));
        if (active > 0 && $urandom_range(2) != 0) begin
          k    = $urandom_range(active - 1);
          trim = ($urandom_range(3) == 0) ? 0 : $urandom_range(64);
          it.request_size = (part_size[k] > trim) ? part_size[k] - REQ_W'(trim) : '0;
        end else begin
          it.request_size = rand_size();
        end
      end
      send_item(it, idle_pct);
    end
  endtask

  // Full-leftover grants until the fragmentation total pins at its ceiling.
  // Run last: the total stays saturated afterwards.
  task automatic test_frag_saturation();
    cfg_write(7'(DEF_MAX_BLOCKS));
    for (int k = 0; k < DEF_MAX_BLOCKS; k++) issue(OP_LOAD, k, 16'hFFFF);
    for (int k = 0; k < DEF_MAX_BLOCKS + 1; k++) issue(OP_REQUEST, k, 0);
    for (int k = 0; k < 2; k++) begin
      issue(OP_LOAD, 63 - k, 16'hFFFF);
      issue(OP_REQUEST, 0, 0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_fill_table();
    test_directed_cases();
    // sender idling: none, heavy, light (the receiver cannot stall)
    test_random(0, 150);
    test_random(81, 150);
    test_random(22, 150);
    test_frag_saturation();

    wait_drained();
    repeat (80) @(posedge clk);
    $display("Covered %0d loads, %0d grants, %0d no-fit requests, %0d rejected loads,",
             n_loads, n_grants, n_nofits, n_rejects);
    $display("over %0d count settings (0, 1, full, oversized), with sender pauses.",
             n_cfg_writes);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // A correct run ends well before this watchdog limit.
  initial begin
    #10ms;
    $display("Timeout: %0d results still outstanding", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- best_fit_partition_allocator.f -----
+incdir+design
design/bfpa_pkg.sv
design/bfpa_ram.sv
design/best_fit_partition_allocator.sv
verif/tb_best_fit_partition_allocator.sv
